// File: src/assert_macros.svh
// Assertion macros shared by the controller's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/pcc_pkg.sv
// Types and constants shared by the PID current controller modules.
package pcc_pkg;

    localparam int DATA_W  = 32;
    localparam int ID_W    = 8;
    localparam int DRIVE_W = 20;
    localparam int ERR_W   = DATA_W + 1;
    localparam int SUM_W   = DATA_W + 2;
    localparam int ACC_W   = 64;
    localparam int IDX_W   = 2;
    localparam int STEP_W  = 6;
    localparam int FRAC_W  = 16;
    localparam int SCALE_W = 29;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 32'd131072;
    localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 32'd196608;
    localparam logic [DATA_W-1:0] DERIV_GAIN_RST = 32'd327680;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 20'sd327680;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -20'sd327680;

    // Smallest sum magnitude whose scaled value exceeds the drive limit.
    localparam logic [ACC_W-1:0]  CLAMP_THRESH = 64'd327681000;
    // Division by 1000 of a magnitude below 2^29 as a multiply by
    // ceil(2^39 / 1000) followed by a right shift of 39.
    localparam logic [DATA_W-1:0] SCALE_RECIP  = 32'd549755814;
    localparam int                SCALE_SHIFT  = 39;
    localparam logic [61:0]       PROD_LIM     = 62'h2000_0000_0000_0000;

    localparam logic [STEP_W-1:0] RATE_STEPS  = STEP_W'(SUM_W + FRAC_W);

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

endpackage

// File: src/pcc_divider.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
`include "assert_macros.svh"

module pcc_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pcc_pkg::t_div_ctl         i_ctl,
    input  logic [pcc_pkg::ACC_W-1:0]  i_num,
    input  logic [pcc_pkg::DATA_W-1:0] i_den,
    output logic                      o_busy,
    output logic [pcc_pkg::ACC_W-1:0]  o_quo
);
    import pcc_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W-1:0] r_rem;
    logic [ACC_W-1:0]  r_num;
    logic [ACC_W-1:0]  r_quo;
    logic [DATA_W:0]   trial;
    logic              fits;

    always_comb begin
        trial = {r_rem, r_num[ACC_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_ctl.steps;
            r_den  <= i_den;
            r_num  <= i_num;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[ACC_W-2:0], 1'b0};
            r_quo <= {r_quo[ACC_W-2:0], fits};
            if (fits) begin
                r_rem <= DATA_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DATA_W-1:0];
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// File: src/pid_current_controller_unit.sv
// Top level of the PID current controller with its sequencer and shared multiplier.
//
// An input word (measured, target, sample time, motor id) is taken when
// i_in_valid is high and o_in_stall is low; o_in_stall is high while a word
// is being worked on. The result word (drive current, clamp flag, id) is
// offered on o_out_valid and is taken when i_out_stall is low.
// One 32 by 32 multiplier, used under a sequencer, forms the integral step,
// the three gain products and the final scaling by 1000, which is taken as a
// multiply by a fixed reciprocal; one restoring divider, one bit per cycle,
// forms the rate term in 50 steps.
// The rate division sets the timing. A clamped result skips the scaling and
// appears sooner, and a new word is taken only when the sequencer is idle.
// A finished result sits in the output register, so the next word can be
// taken while it waits; if the receiver still stalls when the following
// result is ready, the sequencer holds that result until the register frees.
// Reset clears the previous error and the integral, returns the gains to
// 2.0, 3.0 and 5.0, and empties the output register. The user must write the
// gains via the configuration port while idle; the block does not enforce it.
`include "assert_macros.svh"

module pid_current_controller_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [pcc_pkg::DATA_W-1:0]  i_measured,
    input  logic signed [pcc_pkg::DATA_W-1:0]  i_target,
    input  logic [pcc_pkg::DATA_W-1:0]         i_sample_time,
    input  logic [pcc_pkg::ID_W-1:0]           i_motor_id,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [pcc_pkg::DRIVE_W-1:0] o_drive_current,
    output logic                              o_clamped,
    output logic [pcc_pkg::ID_W-1:0]           o_dest_id,
    input  logic                              i_cfg_we,
    input  logic [pcc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [pcc_pkg::DATA_W-1:0]         i_cfg_data
);
    import pcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_ILO, S_IHI, S_IACC, S_IADD,
        S_GLD, S_GLO, S_GHI, S_GACC, S_GSUM,
        S_WRATE, S_ABS, S_SGO, S_WSCALE, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        TERM_PROP, TERM_INTEG, TERM_DERIV
    } t_term;

    t_state r_state;
    t_term  r_k;

    logic [DATA_W-1:0]  r_kp;
    logic [DATA_W-1:0]  r_ki;
    logic [DATA_W-1:0]  r_kd;
    logic [ERR_W-1:0]   r_prev;
    logic [ACC_W-1:0]   r_integ;

    logic [ERR_W-1:0]   r_err;
    logic [DATA_W-1:0]  r_dt;
    logic [ID_W-1:0]    r_id;
    logic [SUM_W-1:0]   r_ms;
    logic               r_s_neg;
    logic [SUM_W-1:0]   r_md;
    logic               r_d_neg;
    logic [ACC_W-1:0]   r_prod;
    logic [ACC_W-1:0]   r_lo;
    logic [48:0]        r_mi;
    logic [DATA_W-1:0]  r_ga;
    logic [ACC_W-1:0]   r_gb;
    logic               r_gneg;
    logic [61:0]        r_m;
    logic [ACC_W-1:0]   r_sum;
    logic               r_out_neg;
    logic               r_clamp;
    logic [SCALE_W-1:0] r_smag;
    logic [DRIVE_W-2:0] r_scaled;

    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_clamp_out;
    logic [ID_W-1:0]           r_dest;

    logic [SUM_W-1:0]   s_sum;
    logic [SUM_W-1:0]   s_diff;
    logic [SUM_W-1:0]   ms;
    logic [SUM_W-1:0]   md;
    logic [ERR_W-1:0]   err_mag;
    logic [ACC_W-1:0]   integ_mag;
    logic [DATA_W-1:0]  gain_sel;
    logic [ACC_W-1:0]   gb_sel;
    logic               bneg_sel;
    logic [DATA_W-1:0]  mul_a;
    logic [DATA_W-1:0]  mul_b;
    logic [ACC_W-1:0]   mul_p;
    logic [SUM_W+DATA_W-1:0] int_full;
    logic [ACC_W:0]     int_add;
    logic [ACC_W-1:0]   prod_join;
    logic [61:0]        m_sat;
    logic [ACC_W-1:0]   sum_mag;
    logic [DRIVE_W-1:0] drive_mag;
    logic [DRIVE_W-1:0] drive_val;

    t_div_ctl           div_ctl;
    logic [ACC_W-1:0]   div_num;
    logic [DATA_W-1:0]  div_den;
    logic               div_busy;
    logic [ACC_W-1:0]   div_quo;

    always_comb begin
        s_sum     = {r_err[ERR_W-1], r_err} + {r_prev[ERR_W-1], r_prev};
        s_diff    = {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};
        ms        = s_sum[SUM_W-1] ? SUM_W'(-s_sum) : s_sum;
        md        = s_diff[SUM_W-1] ? SUM_W'(-s_diff) : s_diff;
        err_mag   = r_err[ERR_W-1] ? ERR_W'(-r_err) : r_err;
        integ_mag = r_integ[ACC_W-1] ? ACC_W'(-r_integ) : r_integ;

        case (r_k)
            TERM_PROP: begin
                gain_sel = r_kp;
                gb_sel   = {{(ACC_W-DATA_W){1'b0}}, err_mag[DATA_W-1:0]};
                bneg_sel = r_err[ERR_W-1];
            end
            TERM_INTEG: begin
                gain_sel = r_ki;
                gb_sel   = integ_mag;
                bneg_sel = r_integ[ACC_W-1];
            end
            TERM_DERIV: begin
                gain_sel = r_kd;
                gb_sel   = (r_dt == '0) ? '0 : div_quo;
                bneg_sel = r_d_neg;
            end
            default: begin
                gain_sel = '0;
                gb_sel   = '0;
                bneg_sel = 1'b0;
            end
        endcase

        case (r_state)
            S_ILO: begin
                mul_a = r_ms[DATA_W-1:0];
                mul_b = r_dt;
            end
            S_IHI: begin
                mul_a = DATA_W'(r_ms[SUM_W-1:DATA_W]);
                mul_b = r_dt;
            end
            S_GHI: begin
                mul_a = r_ga;
                mul_b = r_gb[ACC_W-1:DATA_W];
            end
            S_SGO: begin
                mul_a = {{(DATA_W-SCALE_W){1'b0}}, r_smag};
                mul_b = SCALE_RECIP;
            end
            default: begin
                mul_a = r_ga;
                mul_b = r_gb[DATA_W-1:0];
            end
        endcase
        mul_p = mul_a * mul_b;

        int_full = {r_prod[SUM_W-1:0], {DATA_W{1'b0}}} + {2'b00, r_lo};
        if (r_s_neg) begin
            int_add = {r_integ[ACC_W-1], r_integ} - {16'd0, r_mi};
        end else begin
            int_add = {r_integ[ACC_W-1], r_integ} + {16'd0, r_mi};
        end

        prod_join = {r_prod[47:0], 16'd0} + {16'd0, r_lo[ACC_W-1:FRAC_W]};
        if ((|r_prod[ACC_W-1:45]) || (prod_join > {2'b00, PROD_LIM})) begin
            m_sat = PROD_LIM;
        end else begin
            m_sat = prod_join[61:0];
        end

        sum_mag   = r_sum[ACC_W-1] ? ACC_W'(-r_sum) : r_sum;
        drive_mag = r_clamp ? DRIVE_MAX : {1'b0, r_scaled};
        drive_val = r_out_neg ? DRIVE_W'(-drive_mag) : drive_mag;

        div_ctl.start = (r_state == S_ILO);
        div_ctl.steps = RATE_STEPS;
        div_num       = {r_md, {(ACC_W-SUM_W){1'b0}}};
        div_den       = r_dt;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= TERM_PROP;
            r_kp        <= PROP_GAIN_RST;
            r_ki        <= INTEG_GAIN_RST;
            r_kd        <= DERIV_GAIN_RST;
            r_prev      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROP_GAIN:  r_kp <= i_cfg_data;
                    REG_INTEG_GAIN: r_ki <= i_cfg_data;
                    REG_DERIV_GAIN: r_kd <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_err   <= {i_target[DATA_W-1], i_target}
                                 - {i_measured[DATA_W-1], i_measured};
                        r_dt    <= i_sample_time;
                        r_id    <= i_motor_id;
                        r_sum   <= '0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_ms    <= ms;
                    r_s_neg <= s_sum[SUM_W-1];
                    r_md    <= md;
                    r_d_neg <= s_diff[SUM_W-1];
                    r_prev  <= r_err;
                    r_state <= S_ILO;
                end
                S_ILO: begin
                    r_state <= S_IHI;
                end
                S_IHI: begin
                    r_lo    <= r_prod;
                    r_state <= S_IACC;
                end
                S_IACC: begin
                    r_mi    <= int_full[SUM_W+DATA_W-1:17];
                    r_state <= S_IADD;
                end
                S_IADD: begin
                    if (int_add[ACC_W] != int_add[ACC_W-1]) begin
                        r_integ <= int_add[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                  : {1'b0, {(ACC_W-1){1'b1}}};
                    end else begin
                        r_integ <= int_add[ACC_W-1:0];
                    end
                    r_k     <= TERM_PROP;
                    r_state <= S_GLD;
                end
                S_GLD: begin
                    r_ga    <= gain_sel[DATA_W-1] ? DATA_W'(-gain_sel) : gain_sel;
                    r_gb    <= gb_sel;
                    r_gneg  <= gain_sel[DATA_W-1] ^ bneg_sel;
                    r_state <= S_GLO;
                end
                S_GLO: begin
                    r_state <= S_GHI;
                end
                S_GHI: begin
                    r_lo    <= r_prod;
                    r_state <= S_GACC;
                end
                S_GACC: begin
                    r_m     <= m_sat;
                    r_state <= S_GSUM;
                end
                S_GSUM: begin
                    if (r_gneg) begin
                        r_sum <= r_sum - {2'b00, r_m};
                    end else begin
                        r_sum <= r_sum + {2'b00, r_m};
                    end
                    case (r_k)
                        TERM_PROP: begin
                            r_k     <= TERM_INTEG;
                            r_state <= S_GLD;
                        end
                        TERM_INTEG: begin
                            r_state <= S_WRATE;
                        end
                        default: begin
                            r_state <= S_ABS;
                        end
                    endcase
                end
                S_WRATE: begin
                    if (!div_busy) begin
                        r_k     <= TERM_DERIV;
                        r_state <= S_GLD;
                    end
                end
                S_ABS: begin
                    r_out_neg <= r_sum[ACC_W-1];
                    r_smag    <= sum_mag[SCALE_W-1:0];
                    if (sum_mag >= CLAMP_THRESH) begin
                        r_clamp <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_clamp <= 1'b0;
                        r_state <= S_SGO;
                    end
                end
                S_SGO: begin
                    r_state <= S_WSCALE;
                end
                S_WSCALE: begin
                    r_scaled <= r_prod[SCALE_SHIFT+DRIVE_W-2:SCALE_SHIFT];
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_drive     <= drive_val;
                        r_clamp_out <= r_clamp;
                        r_dest      <= r_id;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    pcc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_drive_current = r_drive;
    assign o_clamped       = r_clamp_out;
    assign o_dest_id       = r_dest;

    `ASSERT_NEXT(a_stall_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "word accepted but the input was not stalled afterwards")
    `ASSERT_HOLDS(a_div_free_on_start, i_clk, i_rst_n, div_ctl.start, !div_busy, "divider started while still busy")
    `ASSERT_HOLDS(a_clamp_at_limit, i_clk, i_rst_n, o_out_valid && o_clamped, o_drive_current == DRIVE_MAX || o_drive_current == DRIVE_MIN, "clamp flag set away from the limit")
    `ASSERT_HOLDS(a_drive_in_range, i_clk, i_rst_n, o_out_valid && !o_clamped, o_drive_current <= DRIVE_MAX && o_drive_current >= DRIVE_MIN, "drive current beyond the limit")

endmodule

// File: test/pid_current_controller_unit_tb.sv
// Self-checking testbench for the PID current controller unit, with its own predictor.
module pid_current_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    localparam logic [IDX_W-1:0]         REG_SPARE      = 2'd3;
    localparam logic [DATA_W-1:0]        DEF_PROP_GAIN  = 32'd131072;
    localparam logic [DATA_W-1:0]        DEF_INTEG_GAIN = 32'd196608;
    localparam logic [DATA_W-1:0]        DEF_DERIV_GAIN = 32'd327680;
    localparam logic signed [DATA_W-1:0] Q_MAX          = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN          = 32'sh8000_0000;
    localparam longint                   DRIVE_LIMIT    = 327680;
    localparam bit [63:0]                PRODUCT_CAP    = 64'h2000_0000_0000_0000;
    localparam longint                   ACC_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint                   ACC_MIN        = 64'sh8000_0000_0000_0000;
    localparam int                       RESET_CYCLES   = 5;
    localparam int                       HOLD_CYCLES    = 600;
    localparam int                       SETTLE_CYCLES  = 100;
    localparam int                       CYCLE_LIMIT    = 1_000_000;
    localparam int                       PHASE_WORDS    = 150;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
        logic [ID_W-1:0]           id;
    } t_drive_word;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [DATA_W-1:0]  i_measured;
    logic signed [DATA_W-1:0]  i_target;
    logic [DATA_W-1:0]         i_sample_time;
    logic [ID_W-1:0]           i_motor_id;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [DRIVE_W-1:0] o_drive_current;
    logic                      o_clamped;
    logic [ID_W-1:0]           o_dest_id;
    logic                      i_cfg_we;
    logic [IDX_W-1:0]          i_cfg_index;
    logic [DATA_W-1:0]         i_cfg_data;

    longint      gain_p;
    longint      gain_i;
    longint      gain_d;
    longint      pid_prev_err;
    longint      pid_integral;
    t_drive_word drive_expected[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          gaps_on;
    bit          stall_on;
    bit          hold_off_req;

    pid_current_controller_unit u_top (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit [63:0] mag64(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint apply_sign(input bit [63:0] m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Gain times value in Q16.16, on magnitudes, capped at 2^61.
    function automatic longint scale_gain(input longint g, input longint v);
        bit [63:0] mg;
        bit [63:0] mv;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] m;
        mg = mag64(g);
        mv = mag64(v);
        hi = mg * (mv >> 32);
        lo = mg * (mv & 64'hFFFF_FFFF);
        if (hi >= (PRODUCT_CAP >> 16)) begin
            m = PRODUCT_CAP;
        end else begin
            m = (hi << 16) + (lo >> 16);
            if (m > PRODUCT_CAP) begin
                m = PRODUCT_CAP;
            end
        end
        return apply_sign(m, (g < 0) != (v < 0));
    endfunction

    function automatic void predict_drive(input logic signed [DATA_W-1:0] meas,
                                          input logic signed [DATA_W-1:0] targ,
                                          input logic [DATA_W-1:0]        dt,
                                          input logic [ID_W-1:0]          id);
        longint             err;
        longint             s;
        longint             d;
        longint             inc;
        longint             rate;
        longint             total;
        longint             cur;
        bit [63:0]          ms;
        bit [63:0]          hi;
        bit [63:0]          lo;
        bit [63:0]          mi;
        bit [63:0]          dt64;
        logic signed [64:0] acc_next;
        t_drive_word        w;
        dt64 = 64'(dt);
        err  = longint'(targ) - longint'(meas);

        s   = err + pid_prev_err;
        ms  = mag64(s);
        hi  = ms * (dt64 >> 16);
        lo  = ms * (dt64 & 64'hFFFF);
        mi  = (hi >> 1) + ((((hi & 64'd1) << 16) + lo) >> 17);
        inc = apply_sign(mi, s < 0);
        acc_next = pid_integral;
        acc_next = acc_next + inc;
        if (acc_next[64] != acc_next[63]) begin
            pid_integral = acc_next[64] ? ACC_MIN : ACC_MAX;
        end else begin
            pid_integral = longint'(acc_next[63:0]);
        end

        d    = err - pid_prev_err;
        rate = 0;
        if (dt != 0) begin
            rate = apply_sign((mag64(d) << 16) / dt64, d < 0);
        end
        pid_prev_err = err;

        total = scale_gain(gain_p, err) + scale_gain(gain_i, pid_integral)
              + scale_gain(gain_d, rate);
        cur = apply_sign(mag64(total) / 64'd1000, total < 0);
        w.clamped = 1'b0;
        if (cur > DRIVE_LIMIT) begin
            cur = DRIVE_LIMIT;
            w.clamped = 1'b1;
        end else if (cur < -DRIVE_LIMIT) begin
            cur = -DRIVE_LIMIT;
            w.clamped = 1'b1;
        end
        w.drive = cur[DRIVE_W-1:0];
        w.id    = id;
        drive_expected.push_back(w);
    endfunction

    function automatic logic signed [DATA_W-1:0] corner_value(input int unsigned k);
        case (k)
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    always @(posedge i_clk) begin : check_drive
        t_drive_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_expected.size() == 0) begin
                $error("unexpected result word: drive_current %0d, clamped %0d, dest_id %0d",
                       o_drive_current, o_clamped, o_dest_id);
                mismatches++;
            end else begin
                want = drive_expected.pop_front();
                if (o_drive_current !== want.drive) begin
                    $error("drive_current: expected %0d, actual %0d",
                           want.drive, o_drive_current);
                    mismatches++;
                end
                if (o_clamped !== want.clamped) begin
                    $error("clamped: expected %0d, actual %0d", want.clamped, o_clamped);
                    mismatches++;
                end
                if (o_dest_id !== want.id) begin
                    $error("dest_id: expected %0d, actual %0d", want.id, o_dest_id);
                    mismatches++;
                end
            end
        end
    end

    // The receiver stalls in random runs, or holds off for a long stretch on request.
    initial begin : out_stall_gen
        int stall_run;
        stall_run   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (stall_run > 0) begin
                stall_run--;
            end else if (stall_on) begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                stall_run    = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150)
                                                            : $urandom_range(0, 6);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] targ,
                             input logic [DATA_W-1:0]        dt,
                             input logic [ID_W-1:0]          id);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_measured    <= meas;
        i_target      <= targ;
        i_sample_time <= dt;
        i_motor_id    <= id;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_drive(meas, targ, dt, id);
        if (gaps_on) begin
            if (burst_left == 0) begin
                @(negedge i_clk);
                i_in_valid    <= 1'b0;
                i_measured    <= $urandom;
                i_target      <= $urandom;
                i_sample_time <= $urandom;
                i_motor_id    <= 8'($urandom_range(0, 255));
                repeat ($urandom_range(0, 100)) @(negedge i_clk);
                burst_left = $urandom_range(0, 6);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_gain(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_PROP_GAIN:  gain_p = signed'(value);
            REG_INTEG_GAIN: gain_i = signed'(value);
            REG_DERIV_GAIN: gain_d = signed'(value);
            default: ;
        endcase
    endtask

    task automatic restore_default_gains();
        write_gain(REG_PROP_GAIN, DEF_PROP_GAIN);
        write_gain(REG_INTEG_GAIN, DEF_INTEG_GAIN);
        write_gain(REG_DERIV_GAIN, DEF_DERIV_GAIN);
    endtask

    task automatic send_random_word(input bit wide_ok);
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] targ;
        logic [DATA_W-1:0]        dt;
        int unsigned              pick;
        pick = $urandom_range(0, 9);
        if (!wide_ok || pick < 6) begin
            meas = $urandom_range(0, 1310720) - 655360;
            targ = $urandom_range(0, 1310720) - 655360;
            dt   = ($urandom_range(0, 15) == 0) ? '0 : $urandom_range(1, 6554);
        end else if (pick < 9) begin
            meas = $urandom;
            targ = $urandom;
            case ($urandom_range(0, 3))
                0:       dt = $urandom;
                1:       dt = $urandom_range(0, 255);
                2:       dt = 32'hFFFF_FFFF;
                default: dt = $urandom_range(0, 65536);
            endcase
        end else begin
            meas = corner_value($urandom_range(0, 3));
            targ = corner_value($urandom_range(0, 3));
            dt   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 2);
        end
        send_word(meas, targ, dt, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random_words(input int count, input bit wide_ok);
        repeat (count) send_random_word(wide_ok);
        drain_results();
    endtask

    // Drives the integral back towards zero with full-scale error words, so that
    // later realistic words give drive currents inside the limit.
    task automatic unwind_integral();
        bit [63:0] span;
        int        steps;
        steps = 0;
        while (mag64(pid_integral) > 64'd1048576 && steps < 64) begin
            span = mag64(pid_integral) >> 15;
            if (span > 64'hFFFF_FFFF) begin
                span = 64'hFFFF_FFFF;
            end
            send_word('0, '0, '0, 8'($urandom_range(0, 255)));
            if (pid_integral > 0) begin
                send_word(Q_MAX, Q_MIN, span[31:0], 8'($urandom_range(0, 255)));
            end else begin
                send_word(Q_MIN, Q_MAX, span[31:0], 8'($urandom_range(0, 255)));
            end
            steps++;
        end
        send_word('0, '0, '0, 8'($urandom_range(0, 255)));
        drain_results();
    endtask

    task automatic test_default_gains();
        send_word(32'sd0, 32'sd65536, 32'd66, 8'h01);
        send_word(32'sd32768, -32'sd32768, 32'd655, 8'h02);
        send_word(32'sd65536, 32'sd65536, 32'd65536, 8'h03);
        drain_results();
    endtask

    task automatic test_zero_sample_time();
        send_word(32'sd0, 32'sd131072, 32'd0, 8'h04);
        send_word(-32'sd65536, 32'sd65536, 32'd0, 8'h05);
        drain_results();
    endtask

    task automatic test_field_extremes();
        send_word(Q_MIN, Q_MAX, 32'hFFFF_FFFF, 8'hFF);
        send_word(Q_MAX, Q_MIN, 32'd1, 8'h00);
        send_word(32'sd0, 32'sd0, 32'h0001_0000, 8'h5A);
        send_word(-32'sd1, -32'sd1, 32'hFFFF_FFFF, 8'hA5);
        drain_results();
    endtask

    // With a unit proportional gain the sum is the error itself, so the drive
    // lands on the limit exactly or just past it.
    task automatic test_drive_limit();
        write_gain(REG_PROP_GAIN, 32'd65536);
        write_gain(REG_INTEG_GAIN, 32'd0);
        write_gain(REG_DERIV_GAIN, 32'd0);
        send_word(32'sd0, 32'sd327680000, 32'd0, 8'h10);
        send_word(32'sd0, 32'sd327680999, 32'd0, 8'h11);
        send_word(32'sd0, 32'sd327681000, 32'd0, 8'h12);
        send_word(32'sd0, -32'sd327680000, 32'd0, 8'h13);
        send_word(32'sd0, -32'sd327681000, 32'd0, 8'h14);
        drain_results();
        restore_default_gains();
    endtask

    task automatic test_unused_register();
        write_gain(REG_SPARE, 32'h0000_0000);
        send_word(32'sd65536, 32'sd0, 32'd66, 8'h20);
        send_word(32'sd0, 32'sd65536, 32'd66, 8'h21);
        drain_results();
    endtask

    task automatic test_gain_extremes();
        write_gain(REG_PROP_GAIN, Q_MAX);
        write_gain(REG_INTEG_GAIN, Q_MIN);
        write_gain(REG_DERIV_GAIN, Q_MIN);
        send_word(32'sd0, 32'sd65536, 32'd66, 8'h30);
        send_word(Q_MIN, Q_MAX, 32'd1, 8'h31);
        send_word(32'sd1000, 32'sd0, 32'd0, 8'h32);
        drain_results();
        write_gain(REG_PROP_GAIN, Q_MIN);
        write_gain(REG_INTEG_GAIN, Q_MAX);
        write_gain(REG_DERIV_GAIN, Q_MAX);
        send_word(Q_MAX, Q_MIN, 32'hFFFF_FFFF, 8'h33);
        send_word(32'sd0, 32'sd0, 32'd1, 8'h34);
        drain_results();
        restore_default_gains();
    endtask

    task automatic test_output_backpressure();
        gaps_on      = 1'b0;
        stall_on     = 1'b0;
        hold_off_req = 1'b1;
        repeat (8) send_random_word(1'b0);
        drain_results();
    endtask

    task automatic test_random_default_gains();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        unwind_integral();
        run_random_words(PHASE_WORDS, 1'b0);
    endtask

    task automatic test_random_full_gains();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        write_gain(REG_PROP_GAIN, $urandom);
        write_gain(REG_INTEG_GAIN, $urandom);
        write_gain(REG_DERIV_GAIN, $urandom);
        run_random_words(PHASE_WORDS, 1'b1);
    endtask

    task automatic test_random_small_gains();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        unwind_integral();
        write_gain(REG_PROP_GAIN, $urandom_range(0, 8191) - 4096);
        write_gain(REG_INTEG_GAIN, 32'd0);
        write_gain(REG_DERIV_GAIN, $urandom_range(0, 511) - 256);
        run_random_words(PHASE_WORDS, 1'b1);
    endtask

    task automatic test_random_extreme_gains();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        unwind_integral();
        write_gain(REG_PROP_GAIN, corner_value($urandom_range(0, 3)));
        write_gain(REG_INTEG_GAIN, corner_value($urandom_range(0, 3)));
        write_gain(REG_DERIV_GAIN, corner_value($urandom_range(0, 3)));
        run_random_words(PHASE_WORDS, 1'b1);
    endtask

    initial begin : main_sequence
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_measured    = '0;
        i_target      = '0;
        i_sample_time = '0;
        i_motor_id    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        gaps_on       = 1'b0;
        stall_on      = 1'b0;
        hold_off_req  = 1'b0;
        gain_p        = signed'(DEF_PROP_GAIN);
        gain_i        = signed'(DEF_INTEG_GAIN);
        gain_d        = signed'(DEF_DERIV_GAIN);
        pid_prev_err  = 0;
        pid_integral  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_gains();
        test_zero_sample_time();
        test_drive_limit();
        test_unused_register();
        test_field_extremes();
        test_gain_extremes();
        test_output_backpressure();
        test_random_default_gains();
        test_random_full_gains();
        test_random_small_gains();
        test_random_extreme_gains();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
